FILE: hw/rtl/scbp_pkg.sv
package scbp_pkg;

   localparam int unsigned ADDR_W  = 48;
   localparam int unsigned BYTES_W = 48;
   localparam int unsigned STAMP_W = 32;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_DEALLOC = 2'd1;
   localparam logic [1:0] ACT_ADD     = 2'd2;
   localparam logic [1:0] ACT_RELEASE = 2'd3;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_TABLE_FULL = 2'd1;
   localparam logic [1:0] ERR_DEQUE_FULL = 2'd2;

   localparam logic [BYTES_W-1:0] MAX_FREE_RESET = 48'd1073741824;

   typedef struct packed {
      logic [1:0]         action;
      logic [BYTES_W-1:0] blk_size;
      logic [ADDR_W-1:0]  block_addr;
      logic               force_req;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  out_addr;
      logic [BYTES_W-1:0] out_size;
      logic               found;
      logic [1:0]         error_code;
      logic [BYTES_W-1:0] total_count;
      logic [BYTES_W-1:0] free_count;
   } rsp_type;

endpackage

FILE: hw/rtl/size_class_block_pool.sv
// Steps: add goes straight to the result; alloc and dealloc scan the buckets one at a time,
// then execute, and an alloc that hands out a block also reads its entry memory.
// Release: unforced and below the limit it ends at once, else it scans the buckets, and each
// bucket holding entries can run the bit-serial age multiplier over a 32-bit stamp difference.
// One item at a time: the input is ready for the next transfer as soon as the result
// is registered. Synchronous reset clears buckets, counters and sets the limit to 2^30.
module size_class_block_pool #(
   parameter int unsigned NUM_BUCKETS = 8,
   parameter int unsigned DEQUE_DEPTH = 16,
   parameter int unsigned AGE_SHIFT   = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scbp_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [47:0]       csr_wdata
);
   import scbp_pkg::*;

   localparam int unsigned BI_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int unsigned DI_W  = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEQUE_DEPTH + 1);
   localparam int unsigned NENT  = NUM_BUCKETS * DEQUE_DEPTH;
   localparam int unsigned EI_W  = $clog2(NENT);
   localparam int unsigned PROD_W = STAMP_W + BYTES_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN   = 4'd1;
   localparam logic [3:0] ST_EXEC   = 4'd2;
   localparam logic [3:0] ST_RD     = 4'd3;
   localparam logic [3:0] ST_RDWAIT = 4'd4;
   localparam logic [3:0] ST_DONE   = 4'd5;
   localparam logic [3:0] ST_RSCAN  = 4'd6;
   localparam logic [3:0] ST_RSTAMP = 4'd7;
   localparam logic [3:0] ST_RMUL   = 4'd8;
   localparam logic [3:0] ST_RPICK  = 4'd9;
   localparam logic [3:0] ST_RSTART = 4'd10;

   logic [3:0]          state_ff, state_in;
   req_type             req_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTES_W-1:0]  max_free_ff;

   logic [BYTES_W-1:0]  size_ff [NUM_BUCKETS];
   logic                bvalid_ff [NUM_BUCKETS];
   logic [DI_W-1:0]     head_ff [NUM_BUCKETS];
   logic [CNT_W-1:0]    count_ff [NUM_BUCKETS];
   logic [STAMP_W-1:0]  seq_ff;
   logic [BYTES_W-1:0]  total_ff, free_ff;

   logic [BI_W-1:0]     idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [BI_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                hole_ff, hole_in;
   logic [BI_W-1:0]     hole_idx_ff, hole_idx_in;
   logic                best_ok_ff, best_ok_in;
   logic [BI_W-1:0]     best_ff, best_in;
   logic [PROD_W-1:0]   best_age_ff, best_age_in;

   // Entry memory: address and stamp, one write port and one registered read.
   logic [ADDR_W-1:0]   mem_addr [NENT];
   logic [STAMP_W-1:0]  mem_stamp [NENT];
   logic                mem_we;
   logic                mem_re;
   logic [EI_W-1:0]     mem_wa, mem_ra;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [STAMP_W-1:0]  rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_addr[mem_wa]  <= req_ff.block_addr;
         mem_stamp[mem_wa] <= seq_ff;
      end
      if (mem_re) begin
         rd_addr_ff  <= mem_addr[mem_ra];
         rd_stamp_ff <= mem_stamp[mem_ra];
      end
   end

   // Shared age multiplier.
   logic               mul_start, mul_done;
   logic [PROD_W-1:0]  mul_p;
   logic [BYTES_W-1:0] size_shift;

   assign size_shift = size_ff[idx_ff] >> AGE_SHIFT;

   scbp_age_mul #(.A_W(STAMP_W), .B_W(BYTES_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (seq_ff - rd_stamp_ff),
      .b       (size_shift),
      .done    (mul_done),
      .product (mul_p)
   );

   function automatic logic [EI_W-1:0] slot(input logic [BI_W-1:0] b,
                                            input logic [DI_W-1:0] off);
      logic [EI_W+BI_W-1:0] base;
      base = (EI_W+BI_W)'(b) * (EI_W+BI_W)'(DEQUE_DEPTH);
      return EI_W'(base) + EI_W'(off);
   endfunction

   // Ring position head + off, wrapped once at the deque depth.
   function automatic logic [DI_W-1:0] ring_pos(input logic [DI_W-1:0]  h,
                                                input logic [CNT_W-1:0] off);
      logic [DI_W+1:0] sum;
      sum = (DI_W+2)'(h) + (DI_W+2)'(off);
      if (sum >= (DI_W+2)'(DEQUE_DEPTH)) begin
         sum = sum - (DI_W+2)'(DEQUE_DEPTH);
      end
      return DI_W'(sum);
   endfunction

   logic [BI_W-1:0]  sel;
   logic             last_idx;
   logic             use_hit;
   logic [DI_W-1:0]  head_sel;
   logic [CNT_W-1:0] cnt_sel;
   logic             do_release;
   logic             done_go;

   assign last_idx   = (idx_ff == BI_W'(NUM_BUCKETS - 1));
   assign use_hit    = hit_ff;
   assign sel        = use_hit ? hit_idx_ff : hole_idx_ff;
   assign head_sel   = use_hit ? head_ff[sel] : '0;
   assign cnt_sel    = use_hit ? count_ff[sel] : '0;
   assign do_release = req_ff.force_req || (free_ff >= max_free_ff);
   // The finished item moves into the output register once that register is free.
   assign done_go    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hole_in      = hole_ff;
      hole_idx_in  = hole_idx_ff;
      best_ok_in   = best_ok_ff;
      best_in      = best_ff;
      best_age_in  = best_age_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b1;
      mem_wa       = slot(sel, ring_pos(head_sel, cnt_sel));
      mem_ra       = slot(idx_ff, head_ff[idx_ff]);
      mul_start    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in     = '0;
               hit_in     = 1'b0;
               hole_in    = 1'b0;
               best_ok_in = 1'b0;
               best_age_in = '0;
               if (req_data.action == ACT_ADD) begin
                  state_in = ST_DONE;
               end else if (req_data.action == ACT_RELEASE) begin
                  state_in = ST_RSCAN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (bvalid_ff[idx_ff] && size_ff[idx_ff] == req_ff.blk_size && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
            end
            if (!bvalid_ff[idx_ff] && !hole_ff) begin
               hole_in     = 1'b1;
               hole_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.action == ACT_DEALLOC && (hit_ff || hole_ff)
                && cnt_sel != CNT_W'(DEQUE_DEPTH)) begin
               mem_we = 1'b1;
            end
            if (req_ff.action == ACT_ALLOC && hit_ff && count_ff[hit_idx_ff] != '0) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            mem_ra   = slot(hit_idx_ff, ring_pos(head_ff[hit_idx_ff],
                                                 count_ff[hit_idx_ff] - 1'b1));
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            mem_re   = 1'b0;
            state_in = ST_DONE;
         end
         ST_RSCAN: begin
            if (!do_release) begin
               state_in = ST_DONE;
            end else if (bvalid_ff[idx_ff] && count_ff[idx_ff] != '0) begin
               state_in = ST_RSTAMP;
            end else if (last_idx) begin
               state_in = best_ok_ff ? ST_RD : ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RSTAMP: begin
            state_in = ST_RSTART;
         end
         ST_RSTART: begin
            if (seq_ff < rd_stamp_ff) begin
               state_in = ST_RPICK;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_RMUL;
            end
         end
         ST_RMUL: begin
            if (mul_done) begin
               if (mul_p > best_age_ff) begin
                  best_ok_in  = 1'b1;
                  best_in     = idx_ff;
                  best_age_in = mul_p;
               end
               state_in = ST_RPICK;
            end
         end
         ST_RPICK: begin
            if (last_idx) begin
               state_in = best_ok_in ? ST_RD : ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RSCAN;
            end
         end
         ST_DONE: begin
            // The read data stays put while the result waits for the output register.
            mem_re = 1'b0;
            if (done_go) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // The release read of the oldest entry reuses the read state.
      if (state_ff == ST_RD && req_ff.action == ACT_RELEASE) begin
         mem_ra = slot(best_ff, head_ff[best_ff]);
      end
   end

   // Result assembly and state update at the end of an item.
   logic [ADDR_W-1:0]  r_addr;
   logic [BYTES_W-1:0] r_size;
   logic               r_found;
   logic [1:0]         r_err;

   always_comb begin
      r_addr  = '0;
      r_size  = '0;
      r_found = 1'b0;
      r_err   = ERR_NONE;
      case (req_ff.action)
         ACT_ALLOC: begin
            if (!hit_ff && !hole_ff) begin
               r_err = ERR_TABLE_FULL;
            end else if (hit_ff && count_ff[hit_idx_ff] != '0) begin
               r_addr  = rd_addr_ff;
               r_found = 1'b1;
            end
         end
         ACT_DEALLOC: begin
            if (!hit_ff && !hole_ff) begin
               r_err = ERR_TABLE_FULL;
            end else if (cnt_sel == CNT_W'(DEQUE_DEPTH)) begin
               r_err = ERR_DEQUE_FULL;
            end
         end
         ACT_RELEASE: begin
            if (do_release && best_ok_ff) begin
               r_addr  = rd_addr_ff;
               r_size  = size_ff[best_ff];
               r_found = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   logic [BYTES_W-1:0] total_in, free_in;

   always_comb begin
      total_in = total_ff;
      free_in  = free_ff;
      if (req_ff.action == ACT_ADD) begin
         total_in = total_ff + req_ff.blk_size;
      end else if (req_ff.action == ACT_ALLOC && r_found) begin
         free_in = free_ff - req_ff.blk_size;
      end else if (req_ff.action == ACT_DEALLOC && r_err == ERR_NONE) begin
         free_in = free_ff + req_ff.blk_size;
      end else if (req_ff.action == ACT_RELEASE && r_found) begin
         free_in  = free_ff - r_size;
         total_in = total_ff - r_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_free_ff  <= MAX_FREE_RESET;
         seq_ff       <= '0;
         total_ff     <= '0;
         free_ff      <= '0;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            size_ff[i]   <= '0;
            bvalid_ff[i] <= 1'b0;
            head_ff[i]   <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            max_free_ff <= csr_wdata;
         end
         if (done_go) begin
            total_ff     <= total_in;
            free_ff      <= free_in;
            // Create the bucket on first use by alloc or dealloc.
            if ((req_ff.action == ACT_ALLOC || req_ff.action == ACT_DEALLOC)
                && !hit_ff && hole_ff) begin
               bvalid_ff[hole_idx_ff] <= 1'b1;
               size_ff[hole_idx_ff]   <= req_ff.blk_size;
               head_ff[hole_idx_ff]   <= '0;
               count_ff[hole_idx_ff]  <= (req_ff.action == ACT_DEALLOC) ? CNT_W'(1) : '0;
            end
            if (req_ff.action == ACT_DEALLOC && r_err == ERR_NONE) begin
               seq_ff <= seq_ff + 1'b1;
               if (hit_ff) begin
                  count_ff[hit_idx_ff] <= count_ff[hit_idx_ff] + 1'b1;
               end
            end
            if (req_ff.action == ACT_ALLOC && r_found) begin
               count_ff[hit_idx_ff] <= count_ff[hit_idx_ff] - 1'b1;
            end
            if (req_ff.action == ACT_RELEASE && r_found) begin
               head_ff[best_ff]  <= ring_pos(head_ff[best_ff], CNT_W'(1));
               count_ff[best_ff] <= count_ff[best_ff] - 1'b1;
            end
         end
      end
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (done_go) begin
         rsp_ff <= '{out_addr: r_addr, out_size: r_size, found: r_found,
                     error_code: r_err, total_count: total_in, free_count: free_in};
      end else begin
         rsp_ff <= rsp_in;
      end
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hole_ff     <= hole_in;
      hole_idx_ff <= hole_idx_in;
      best_ok_ff  <= best_ok_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: hw/rtl/scbp_age_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle.
module scbp_age_mul #(
   parameter int unsigned A_W = 32,
   parameter int unsigned B_W = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);
   localparam int unsigned CNT_W = $clog2(A_W + 1);

   logic [A_W-1:0]     a_ff, a_in;
   logic [A_W+B_W-1:0] b_ff, b_in, acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   // One partial product is added per cycle, low bit of a first.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         b_in    = {{A_W{1'b0}}, b};
         acc_in  = '0;
         cnt_in  = CNT_W'(A_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         a_in   = a_ff >> 1;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = busy_ff && (cnt_ff == CNT_W'(1)) && !start;
   assign product = a_ff[0] ? (acc_ff + b_ff) : acc_ff;
endmodule

FILE: hw/rtl/scbp_checker.sv
module scbp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input scbp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scbp_pkg::rsp_type rsp_data
);
   import scbp_pkg::*;

   // A held result keeps its payload until transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Only one item is in work: the input closes right after a transfer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open while an item is in work");

   // A found block never comes with an error.
   a_found_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.error_code == ERR_NONE)
      else $error("found with error");

   // Without a found block, address and size read as zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.out_addr == '0 && rsp_data.out_size == '0)
      else $error("address or size without a found block");
endmodule

bind size_class_block_pool scbp_checker u_scbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scbp_pkg::*;

   localparam int NBUCK  = 8;
   localparam int DEPTH  = 16;
   localparam int SHIFT  = 20;
   localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

   // Tracks the pool contents and predicts one result per accepted request.
   class pool_scoreboard;
      logic [47:0] limit;
      logic [47:0] sizes [NBUCK];
      bit          used [NBUCK];
      logic [47:0] addrs [NBUCK*DEPTH];
      logic [31:0] stamps [NBUCK*DEPTH];
      int          heads [NBUCK];
      int          counts [NBUCK];
      logic [31:0] seq;
      logic [47:0] held_sum;
      logic [47:0] free_sum;
      rsp_type     pending [$];
      int          mismatches;

      function new();
         limit = MAX_FREE_RESET;
         seq = '0;
         held_sum = '0;
         free_sum = '0;
         mismatches = 0;
         for (int b = 0; b < NBUCK; b++) begin
            used[b] = 0;
            sizes[b] = '0;
            heads[b] = 0;
            counts[b] = 0;
         end
      endfunction

      // Matching bucket, or a newly created one; -1 when the table is full.
      function int bucket_for(logic [47:0] size);
         for (int b = 0; b < NBUCK; b++)
            if (used[b] && sizes[b] == size) return b;
         for (int b = 0; b < NBUCK; b++)
            if (!used[b]) begin
               used[b] = 1;
               sizes[b] = size;
               heads[b] = 0;
               counts[b] = 0;
               return b;
            end
         return -1;
      endfunction

      // Bucket whose oldest entry has the strictly largest positive age.
      function int oldest_bucket();
         logic [63:0] best;
         logic [63:0] age;
         logic [31:0] st;
         int          pick;
         best = '0;
         pick = -1;
         for (int b = 0; b < NBUCK; b++) begin
            if (!used[b] || counts[b] == 0) continue;
            st = stamps[b*DEPTH + heads[b]];
            if (seq < st) continue;
            age = 64'(seq - st) * 64'(sizes[b] >> SHIFT);
            if (age > best) begin
               best = age;
               pick = b;
            end
         end
         return pick;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      b;
         int      s;
         e = '0;
         case (r.action)
            ACT_ALLOC: begin
               b = bucket_for(r.blk_size);
               if (b < 0) e.error_code = ERR_TABLE_FULL;
               else if (counts[b] != 0) begin
                  e.out_addr = addrs[b*DEPTH + (heads[b] + counts[b] - 1) % DEPTH];
                  counts[b]--;
                  e.found = 1'b1;
                  free_sum = free_sum - r.blk_size;
               end
            end
            ACT_DEALLOC: begin
               b = bucket_for(r.blk_size);
               if (b < 0) e.error_code = ERR_TABLE_FULL;
               else if (counts[b] >= DEPTH) e.error_code = ERR_DEQUE_FULL;
               else begin
                  s = b*DEPTH + (heads[b] + counts[b]) % DEPTH;
                  addrs[s] = r.block_addr;
                  stamps[s] = seq;
                  counts[b]++;
                  seq = seq + 1;
                  free_sum = free_sum + r.blk_size;
               end
            end
            ACT_ADD: held_sum = held_sum + r.blk_size;
            default: begin
               if (r.force_req || free_sum >= limit) begin
                  b = oldest_bucket();
                  if (b >= 0) begin
                     e.out_addr = addrs[b*DEPTH + heads[b]];
                     e.out_size = sizes[b];
                     heads[b] = (heads[b] + 1) % DEPTH;
                     counts[b]--;
                     e.found = 1'b1;
                     free_sum = free_sum - sizes[b];
                     held_sum = held_sum - sizes[b];
                  end
               end
            end
         endcase
         e.total_count = held_sum;
         e.free_count = free_sum;
         pending.push_back(e);
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (got.out_addr !== e.out_addr)
            report_mismatch($sformatf("out_addr %h, expected %h", got.out_addr, e.out_addr));
         if (got.out_size !== e.out_size)
            report_mismatch($sformatf("out_size %h, expected %h", got.out_size, e.out_size));
         if (got.found !== e.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, e.found));
         if (got.error_code !== e.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, e.error_code));
         if (got.total_count !== e.total_count)
            report_mismatch($sformatf("total_count %h, expected %h",
                                      got.total_count, e.total_count));
         if (got.free_count !== e.free_count)
            report_mismatch($sformatf("free_count %h, expected %h",
                                      got.free_count, e.free_count));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write;
   logic [47:0] csr_wdata;

   pool_scoreboard pool_model;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;
   logic [47:0] size_set [NBUCK];

   size_class_block_pool dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver either stalls at random or holds off for a counted stretch.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every result transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) pool_model.check_response(rsp_data);
   end

   // Offer one request, with an optional random gap first, and wait for its transfer.
   task automatic send_request(req_type r);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pool_model.note_request(r);
   endtask

   task automatic send_fields(logic [1:0] act, logic [47:0] size, logic [47:0] addr,
                              logic frc);
      req_type r;
      r.action = act;
      r.blk_size = size;
      r.block_addr = addr;
      r.force_req = frc;
      send_request(r);
   endtask

   // Stop offering and wait until every predicted result has been seen.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pool_model.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_limit(logic [47:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      pool_model.limit = value;
   endtask

   // Mostly sizes from the working set; now and then an unknown size.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.block_addr = 48'({$urandom(), $urandom()});
      r.force_req = 1'($urandom_range(1));
      r.blk_size = size_set[$urandom_range(NBUCK-1)];
      if (pick < 38) r.action = ACT_DEALLOC;
      else if (pick < 62) r.action = ACT_ALLOC;
      else if (pick < 72) r.action = ACT_ADD;
      else if (pick < 95) r.action = ACT_RELEASE;
      else begin
         r.action = 2'($urandom_range(3));
         r.blk_size = 48'({$urandom(), $urandom()});
      end
      if (r.action == ACT_ADD && $urandom_range(1)) r.blk_size = 48'({$urandom(), $urandom()});
      return r;
   endfunction

   initial begin
      logic [47:0] limits [4];
      int          idle_modes [4];
      int          stall_modes [4];
      pool_model = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      size_set[0] = 48'h10_0000;
      size_set[1] = '0;
      size_set[2] = ALL_ONES;
      size_set[3] = 48'h40_0000;
      size_set[4] = 48'({$urandom(), $urandom()});
      size_set[5] = 48'h1000;
      size_set[6] = 48'({$urandom(), $urandom()}) | 48'h8000_0000_0000;
      size_set[7] = 48'h300_0000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty release, extremes, table full, deque full.
      send_fields(ACT_RELEASE, '0, '0, 1'b1);
      send_fields(ACT_ADD, ALL_ONES, '0, 1'b0);
      send_fields(ACT_ADD, 48'd1, ALL_ONES, 1'b1);
      send_fields(ACT_ALLOC, size_set[0], '0, 1'b0);
      send_fields(ACT_DEALLOC, size_set[1], ALL_ONES, 1'b0);
      send_fields(ACT_DEALLOC, size_set[2], '0, 1'b1);
      send_fields(ACT_RELEASE, '0, '0, 1'b0);
      for (int i = 3; i < NBUCK; i++)
         send_fields(ACT_DEALLOC, size_set[i], 48'({$urandom(), $urandom()}), 1'b0);
      send_fields(ACT_DEALLOC, 48'h123_4567, 48'h55, 1'b0);
      send_fields(ACT_ALLOC, 48'h123_4567, '0, 1'b0);
      for (int i = 0; i <= DEPTH; i++)
         send_fields(ACT_DEALLOC, size_set[0], 48'({$urandom(), $urandom()}), 1'b0);
      send_fields(ACT_ALLOC, size_set[0], '0, 1'b0);
      send_fields(ACT_RELEASE, '0, '0, 1'b1);
      drain();

      // Random phases under different idling and limit settings.
      limits[0] = '0;
      limits[1] = ALL_ONES;
      limits[2] = 48'h4000_0000;
      limits[3] = 48'({$urandom(), $urandom()} >> $urandom_range(47));
      idle_modes = '{0, 49, 0, 15};
      stall_modes = '{0, 0, 49, 15};
      for (int ph = 0; ph < 4; ph++) begin
         write_limit(limits[ph]);
         send_idle_pct = idle_modes[ph];
         recv_stall_pct = stall_modes[ph];
         if (ph == 2) hold_off_cycles = 600;
         for (int n = 0; n < 380; n++) send_request(random_request());
         drain();
      end

      if (pool_model.mismatches == 0 && pool_model.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (pool_model.pending.size() != 0)
            pool_model.report_mismatch("predicted results never arrived");
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/scbp_pkg.sv
hw/rtl/scbp_age_mul.sv
hw/rtl/size_class_block_pool.sv
hw/rtl/scbp_checker.sv
test/testbench.sv
